### rtl/bir_pkg.sv
// ---------------------------------------------------------------------------
// bir_pkg
// shared widths, codes and types of the bilinear image resampler
// ---------------------------------------------------------------------------
package bir_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_CHANNELS   = 3;

  localparam int COORD_W   = 12;
  localparam int STEP_W    = 24;
  localparam int FRAC_W    = 16;
  localparam int PROD_W    = COORD_W + STEP_W;
  localparam int INT_W     = PROD_W - FRAC_W;
  localparam int PIX_W     = 8;
  localparam int CH_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = STEP_W;

  localparam int FIFO_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP = 2'd2;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [STEP_W-1:0] STEP_ONE = 24'd65536;

  typedef logic [1:0] kind_t;
  localparam kind_t K_WRITE = 2'd0;
  localparam kind_t K_ZERO  = 2'd1;
  localparam kind_t K_ONE   = 2'd2;
  localparam kind_t K_FOUR  = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] r0;
    logic [COORD_W-1:0] r1;
    logic [COORD_W-1:0] c0;
    logic [COORD_W-1:0] c1;
    logic [CH_W-1:0]    ch;
    logic [PIX_W-1:0]   val;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
  } cmd_t;

endpackage

### rtl/bir_if.sv
// ---------------------------------------------------------------------------
// bir_in_if / bir_out_if
// valid/ready channels of the resampler
// ---------------------------------------------------------------------------
interface bir_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [bir_pkg::COORD_W-1:0] row;
  logic [bir_pkg::COORD_W-1:0] col;
  logic [bir_pkg::CH_W-1:0]    channel;
  logic [bir_pkg::PIX_W-1:0]   value;

  modport source (output valid, operation, row, col, channel, value, input ready);
  modport sink   (input valid, operation, row, col, channel, value, output ready);
endinterface

interface bir_out_if;
  logic                      valid;
  logic                      ready;
  logic [bir_pkg::PIX_W-1:0] pixel_value;
  logic [bir_pkg::CH_W-1:0]  channel_out;

  modport source (output valid, pixel_value, channel_out, input ready);
  modport sink   (input valid, pixel_value, channel_out, output ready);
endinterface

### rtl/bir_front.sv
// ---------------------------------------------------------------------------
// bir_front
// takes input beats, scales coordinates and sorts them into commands
// ---------------------------------------------------------------------------
module bir_front #(
  parameter int MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNELS   = bir_pkg::DEF_CHANNELS
) (
  input  logic          clk,
  input  logic          rst_n,
  bir_in_if.sink        in_chan,
  input  bir_pkg::cfg_t cfg,
  output bir_pkg::cmd_t push_cmd,
  output logic          push,
  input  logic          full
);
  import bir_pkg::*;

  localparam int CMP_W = COORD_W + 1;
  localparam logic [INT_W-1:0]   Y_LIM  = INT_W'(MAX_HEIGHT);
  localparam logic [INT_W-1:0]   Y_LIM1 = INT_W'(MAX_HEIGHT - 1);
  localparam logic [INT_W-1:0]   X_LIM  = INT_W'(MAX_WIDTH);
  localparam logic [INT_W-1:0]   X_LIM1 = INT_W'(MAX_WIDTH - 1);
  localparam logic [COORD_W-1:0] Y_TOP  = COORD_W'(MAX_HEIGHT - 1);
  localparam logic [COORD_W-1:0] X_TOP  = COORD_W'(MAX_WIDTH - 1);
  localparam logic [CMP_W-1:0]   ROW_LIM = CMP_W'(MAX_HEIGHT);
  localparam logic [CMP_W-1:0]   COL_LIM = CMP_W'(MAX_WIDTH);
  localparam logic [CH_W:0]      CH_LIM  = (CH_W + 1)'(CHANNELS);

  logic               f1_v_r, f1_v_nxt;
  logic               f1_op_r;
  logic [COORD_W-1:0] f1_row_r, f1_col_r;
  logic [CH_W-1:0]    f1_ch_r;
  logic [PIX_W-1:0]   f1_val_r;
  logic [PROD_W-1:0]  f1_yp_r, f1_xp_r;

  logic               accept, advance, drop;
  logic [INT_W-1:0]   yint, xint;
  logic [FRAC_W-1:0]  fy, fx;
  logic               ch_ok;

  assign accept = in_chan.valid && in_chan.ready;
  assign advance = f1_v_r && (drop || !full);
  assign in_chan.ready = !f1_v_r || advance;
  assign push = f1_v_r && !drop && !full;

  always_comb begin
    f1_v_nxt = f1_v_r;
    if (advance) f1_v_nxt = 1'b0;
    if (accept) f1_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= f1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op_r  <= in_chan.operation;
      f1_row_r <= in_chan.row;
      f1_col_r <= in_chan.col;
      f1_ch_r  <= in_chan.channel;
      f1_val_r <= in_chan.value;
      f1_yp_r  <= PROD_W'(in_chan.row) * PROD_W'(cfg.y_step);
      f1_xp_r  <= PROD_W'(in_chan.col) * PROD_W'(cfg.x_step);
    end
  end

  // classify the held beat
  always_comb begin
    yint  = f1_yp_r[PROD_W-1:FRAC_W];
    xint  = f1_xp_r[PROD_W-1:FRAC_W];
    fy    = f1_yp_r[FRAC_W-1:0];
    fx    = f1_xp_r[FRAC_W-1:0];
    ch_ok = {1'b0, f1_ch_r} < CH_LIM;
    drop  = (f1_op_r == OP_WRITE) &&
            !(({1'b0, f1_row_r} < ROW_LIM) && ({1'b0, f1_col_r} < COL_LIM) && ch_ok);

    push_cmd     = '0;
    push_cmd.ch  = f1_ch_r;
    push_cmd.val = f1_val_r;
    push_cmd.fx  = fx;
    push_cmd.fy  = fy;
    if (f1_op_r == OP_WRITE) begin
      push_cmd.kind = K_WRITE;
      push_cmd.r0   = f1_row_r;
      push_cmd.c0   = f1_col_r;
    end else begin
      push_cmd.r0 = (yint >= Y_LIM)  ? Y_TOP : yint[COORD_W-1:0];
      push_cmd.c0 = (xint >= X_LIM)  ? X_TOP : xint[COORD_W-1:0];
      push_cmd.r1 = (yint >= Y_LIM1) ? Y_TOP : yint[COORD_W-1:0] + 1'b1;
      push_cmd.c1 = (xint >= X_LIM1) ? X_TOP : xint[COORD_W-1:0] + 1'b1;
      if (!ch_ok) begin
        push_cmd.kind = K_ZERO;
      end else if (cfg.mode == MODE_NEAREST || (fx == '0 && fy == '0)) begin
        push_cmd.kind = K_ONE;
      end else begin
        push_cmd.kind = K_FOUR;
      end
    end
  end

endmodule

### rtl/bir_fifo.sv
// ---------------------------------------------------------------------------
// bir_fifo
// short command queue between front and back
// ---------------------------------------------------------------------------
module bir_fifo #(
  parameter int DEPTH = bir_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  bir_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output bir_pkg::cmd_t rd_data,
  output logic          rd_valid
);
  import bir_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full     = cnt_r == FULL_CNT;
  assign rd_valid = cnt_r != '0;
  assign rd_data  = entry_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) entry_r[wr_ptr_r] <= wr_data;
  end

endmodule

### rtl/bir_back.sv
// ---------------------------------------------------------------------------
// bir_back
// pixel store, neighbour fetch sequencer, blend and result register
// ---------------------------------------------------------------------------
module bir_back #(
  parameter int MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNELS   = bir_pkg::DEF_CHANNELS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bir_pkg::cmd_t head,
  input  logic          head_v,
  output logic          pop,
  bir_out_if.source     out_chan
);
  import bir_pkg::*;

  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = RW + CW + CHW;
  localparam int DEPTH = 1 << AW;
  localparam int LW    = 26;
  localparam int MW    = 42;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ONE  = 3'd1;
  localparam logic [2:0] S_F1   = 3'd2;
  localparam logic [2:0] S_F2   = 3'd3;
  localparam logic [2:0] S_F3   = 3'd4;
  localparam logic [2:0] S_LAST = 3'd5;
  localparam logic [2:0] S_MIX  = 3'd6;

  function automatic logic [AW-1:0] mk_addr(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                            logic [CH_W-1:0] ch);
    mk_addr = {r[RW-1:0], c[CW-1:0], ch[CHW-1:0]};
  endfunction

  // a + (b - a) * f, Q8.16
  function automatic logic signed [LW-1:0] lerp(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                                logic [FRAC_W-1:0] f);
    logic signed [PIX_W:0]  d;
    logic signed [LW-1:0]   dx, fs, base;
    d    = $signed({1'b0, b}) - $signed({1'b0, a});
    dx   = LW'(d);
    fs   = $signed(LW'(f));
    base = $signed(LW'({a, {FRAC_W{1'b0}}}));
    lerp = base + dx * fs;
  endfunction

  logic [PIX_W-1:0] pix_mem [DEPTH];
  logic [PIX_W-1:0] rdata_r;

  logic [2:0]           state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [PIX_W-1:0]     ul_r, ul_nxt, ur_r, ur_nxt, ll_r, ll_nxt;
  logic signed [LW-1:0] top_r, top_nxt, bot_r, bot_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [PIX_W-1:0]     out_pix_r, out_pix_nxt;
  logic [CH_W-1:0]      out_ch_r, out_ch_nxt;

  logic                 we, re, out_free;
  logic [AW-1:0]        addr;
  logic signed [MW-1:0] t_ext, dm, mix;

  assign out_free = !out_v_r || out_chan.ready;

  assign out_chan.valid       = out_v_r;
  assign out_chan.pixel_value = out_pix_r;
  assign out_chan.channel_out = out_ch_r;

  always_comb begin
    t_ext = MW'(top_r);
    dm    = MW'(bot_r) - t_ext;
    mix   = (t_ext <<< FRAC_W) + dm * $signed(MW'(cmd_r.fy));
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    ul_nxt      = ul_r;
    ur_nxt      = ur_r;
    ll_nxt      = ll_r;
    top_nxt     = top_r;
    bot_nxt     = bot_r;
    out_v_nxt   = out_v_r && !out_chan.ready;
    out_pix_nxt = out_pix_r;
    out_ch_nxt  = out_ch_r;
    we          = 1'b0;
    re          = 1'b0;
    pop         = 1'b0;
    addr        = mk_addr(head.r0, head.c0, head.ch);

    case (state_r)
      S_IDLE: begin
        if (head_v) begin
          case (head.kind)
            K_WRITE: begin
              we  = 1'b1;
              pop = 1'b1;
            end
            K_ZERO: begin
              if (out_free) begin
                pop         = 1'b1;
                out_v_nxt   = 1'b1;
                out_pix_nxt = '0;
                out_ch_nxt  = head.ch;
              end
            end
            K_ONE: begin
              re        = 1'b1;
              pop       = 1'b1;
              cmd_nxt   = head;
              state_nxt = S_ONE;
            end
            default: begin
              re        = 1'b1;
              pop       = 1'b1;
              cmd_nxt   = head;
              state_nxt = S_F1;
            end
          endcase
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_v_nxt   = 1'b1;
          out_pix_nxt = rdata_r;
          out_ch_nxt  = cmd_r.ch;
          state_nxt   = S_IDLE;
        end
      end
      S_F1: begin
        re        = 1'b1;
        addr      = mk_addr(cmd_r.r0, cmd_r.c1, cmd_r.ch);
        ul_nxt    = rdata_r;
        state_nxt = S_F2;
      end
      S_F2: begin
        re        = 1'b1;
        addr      = mk_addr(cmd_r.r1, cmd_r.c0, cmd_r.ch);
        ur_nxt    = rdata_r;
        state_nxt = S_F3;
      end
      S_F3: begin
        re        = 1'b1;
        addr      = mk_addr(cmd_r.r1, cmd_r.c1, cmd_r.ch);
        ll_nxt    = rdata_r;
        top_nxt   = lerp(ul_r, ur_r, cmd_r.fx);
        state_nxt = S_LAST;
      end
      S_LAST: begin
        bot_nxt   = lerp(ll_r, rdata_r, cmd_r.fx);
        state_nxt = S_MIX;
      end
      S_MIX: begin
        if (out_free) begin
          out_v_nxt   = 1'b1;
          out_pix_nxt = mix[2*FRAC_W+PIX_W-1:2*FRAC_W];
          out_ch_nxt  = cmd_r.ch;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    ul_r      <= ul_nxt;
    ur_r      <= ur_nxt;
    ll_r      <= ll_nxt;
    top_r     <= top_nxt;
    bot_r     <= bot_nxt;
    out_pix_r <= out_pix_nxt;
    out_ch_r  <= out_ch_nxt;
  end

  // single port pixel store
  always_ff @(posedge clk) begin
    if (we) pix_mem[addr] <= head.val;
    if (re) rdata_r <= pix_mem[addr];
  end

endmodule

### rtl/bilinear_image_resampler_top.sv
// ---------------------------------------------------------------------------
// bilinear_image_resampler_top
// pixel store with nearest and bilinear resampling of stored images
//
//   channel   dir  beat contents
//   in_chan   in   operation, row, col, channel, value
//   out_chan  out  pixel_value, channel_out
//   cfg_*     in   cfg_we, cfg_index, cfg_wdata (mode, x_step, y_step)
//
// write beat: stored in the back end, no result
// nearest or copy sample: a single read of the store; bilinear sample: four reads
// of the single port pixel store plus two blend steps
// front end takes beats into a 2 deep queue while the back end works
// sync reset clears control state and the config registers; data registers and the pixel store are not cleared
// result register holds a stalled result while input continues
// ---------------------------------------------------------------------------
module bilinear_image_resampler_top #(
  parameter int MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNELS   = bir_pkg::DEF_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bir_in_if.sink                          in_chan,
  bir_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [bir_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bir_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import bir_pkg::*;

  logic              mode_r, mode_nxt;
  logic [STEP_W-1:0] x_step_r, x_step_nxt, y_step_r, y_step_nxt;
  cfg_t              cfg;
  cmd_t              push_cmd, head;
  logic              push, full, pop, head_v;

  always_comb begin
    mode_nxt   = mode_r;
    x_step_nxt = x_step_r;
    y_step_nxt = y_step_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_nxt   = cfg_wdata[0];
        REG_X_STEP: x_step_nxt = cfg_wdata;
        REG_Y_STEP: y_step_nxt = cfg_wdata;
        default:    mode_nxt   = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BILINEAR;
      x_step_r <= STEP_ONE;
      y_step_r <= STEP_ONE;
    end else begin
      mode_r   <= mode_nxt;
      x_step_r <= x_step_nxt;
      y_step_r <= y_step_nxt;
    end
  end

  assign cfg.mode   = mode_r;
  assign cfg.x_step = x_step_r;
  assign cfg.y_step = y_step_r;

  bir_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg      (cfg),
    .push_cmd (push_cmd),
    .push     (push),
    .full     (full)
  );

  bir_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (push_cmd),
    .full     (full),
    .rd_en    (pop),
    .rd_data  (head),
    .rd_valid (head_v)
  );

  bir_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CHANNELS   (CHANNELS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_v   (head_v),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

### rtl/bir_checker.sv
// ---------------------------------------------------------------------------
// bir_checker
// port level checks of the resampler, bound to the top level
// ---------------------------------------------------------------------------
module bir_checker #(
  parameter int CHANNELS = bir_pkg::DEF_CHANNELS
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bir_pkg::PIX_W-1:0]     pixel_value,
  input logic [bir_pkg::CH_W-1:0]      channel_out
);
  import bir_pkg::*;

  localparam logic [CH_W:0] CH_LIM = (CH_W + 1)'(CHANNELS);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pixel_value) && $stable(channel_out))
    else $error("result beat changed while stalled");

  a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ({1'b0, channel_out} >= CH_LIM) |-> pixel_value == '0)
    else $error("nonzero value for channel outside the image");

  a_reset_exit: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid && in_ready)
    else $error("bad handshake state after reset");

endmodule

bind bilinear_image_resampler_top bir_checker #(.CHANNELS(CHANNELS)) u_bir_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .pixel_value (out_chan.pixel_value),
  .channel_out (out_chan.channel_out)
);

### tb/bilinear_image_resampler_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bilinear_image_resampler_top_tb
// fills the pixel store with write beats and checks every sample beat
// against a resampling of the bench's own copy of the store, over nearest
// and bilinear modes, step extremes, saturated coordinates and stalls
// ---------------------------------------------------------------------------
module bilinear_image_resampler_top_tb;
  import bir_pkg::*;

  localparam int MAX_W         = DEF_MAX_WIDTH;
  localparam int MAX_H         = DEF_MAX_HEIGHT;
  localparam int NCH           = DEF_CHANNELS;
  localparam int STORE_DEPTH   = MAX_W * MAX_H * NCH;
  localparam int CH_TOP        = 2 ** CH_W - 1;
  localparam int COORD_TOP     = 2 ** COORD_W - 1;
  localparam longint FRAC_ONE  = 65536;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 24;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [CH_W-1:0]    ch;
    logic [PIX_W-1:0]   value;
  } beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CH_W-1:0]  ch;
  } pixel_t;

  typedef struct {
    int r0;
    int r1;
    int c0;
    int c1;
    int fx;
    int fy;
  } taps_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;

  bir_in_if  in_chan ();
  bir_out_if out_chan ();

  bilinear_image_resampler_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic              mode_r;
  logic [STEP_W-1:0] x_step_r;
  logic [STEP_W-1:0] y_step_r;
  logic [PIX_W-1:0]  pix_mem [STORE_DEPTH];
  bit                written [STORE_DEPTH];

  beat_t  beats_to_send [$];
  pixel_t due_pixels [$];
  beat_t  next_beat;
  pixel_t due;
  logic   in_fire;

  int unsigned n_queued, n_taken, n_writes, n_samples, n_checked, n_errors, n_settings;
  int unsigned cycle_count;
  int unsigned send_idle_pct, recv_idle_pct;

  function automatic int clamp_index(longint unsigned v, int lim);
    return (v >= lim) ? lim - 1 : int'(v[31:0]);
  endfunction

  function automatic int addr_of(int r, int c, int ch);
    return (r * MAX_W + c) * NCH + ch;
  endfunction

  function automatic taps_t locate(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
    logic [PROD_W-1:0] yc;
    logic [PROD_W-1:0] xc;
    taps_t             t;
    yc   = row * y_step_r;
    xc   = col * x_step_r;
    t.r0 = clamp_index(yc[PROD_W-1:FRAC_W], MAX_H);
    t.r1 = clamp_index(yc[PROD_W-1:FRAC_W] + 1, MAX_H);
    t.c0 = clamp_index(xc[PROD_W-1:FRAC_W], MAX_W);
    t.c1 = clamp_index(xc[PROD_W-1:FRAC_W] + 1, MAX_W);
    t.fy = yc[FRAC_W-1:0];
    t.fx = xc[FRAC_W-1:0];
    return t;
  endfunction

  function automatic bit blends(taps_t t);
    return mode_r == MODE_BILINEAR && (t.fx != 0 || t.fy != 0);
  endfunction

  function automatic logic [PIX_W-1:0] predict_resample(logic [COORD_W-1:0] row,
                                                        logic [COORD_W-1:0] col,
                                                        logic [CH_W-1:0] ch);
    taps_t  t;
    longint ul, ur, ll, lr, top, bot, mix, res;
    if (ch >= NCH) return '0;
    t  = locate(row, col);
    ul = pix_mem[addr_of(t.r0, t.c0, ch)];
    if (!blends(t)) return ul[PIX_W-1:0];
    ur  = pix_mem[addr_of(t.r0, t.c1, ch)];
    ll  = pix_mem[addr_of(t.r1, t.c0, ch)];
    lr  = pix_mem[addr_of(t.r1, t.c1, ch)];
    top = ul * FRAC_ONE + (ur - ul) * t.fx;
    bot = ll * FRAC_ONE + (lr - ll) * t.fx;
    mix = top * FRAC_ONE + (bot - top) * t.fy;
    if (mix < 0) mix = 0;
    res = mix >>> 32;
    if (res > 255) res = 255;
    return res[PIX_W-1:0];
  endfunction

  function automatic void take_beat(logic op, logic [COORD_W-1:0] row,
                                    logic [COORD_W-1:0] col, logic [CH_W-1:0] ch,
                                    logic [PIX_W-1:0] value);
    pixel_t p;
    if (op == OP_WRITE) begin
      if (row < MAX_H && col < MAX_W && ch < NCH) pix_mem[addr_of(row, col, ch)] = value;
    end else begin
      p.pixel = predict_resample(row, col, ch);
      p.ch    = ch;
      due_pixels.push_back(p);
    end
  endfunction

  function automatic void queue_beat(logic op, int row, int col, int ch, int value);
    beat_t b;
    b.op    = op;
    b.row   = COORD_W'(row);
    b.col   = COORD_W'(col);
    b.ch    = CH_W'(ch);
    b.value = PIX_W'(value);
    if (op == OP_WRITE) begin
      n_writes++;
      if (row < MAX_H && col < MAX_W && ch < NCH) written[addr_of(row, col, ch)] = 1'b1;
    end else begin
      n_samples++;
    end
    beats_to_send.push_back(b);
    n_queued++;
  endfunction

  function automatic void prime(int r, int c, int ch);
    if (!written[addr_of(r, c, ch)]) queue_beat(OP_WRITE, r, c, ch, $urandom_range(255));
  endfunction

  // every pixel a sample reads is written first
  function automatic void queue_sample(int row, int col, int ch);
    taps_t t;
    if (ch < NCH) begin
      t = locate(COORD_W'(row), COORD_W'(col));
      prime(t.r0, t.c0, ch);
      if (blends(t)) begin
        prime(t.r0, t.c1, ch);
        prime(t.r1, t.c0, ch);
        prime(t.r1, t.c1, ch);
      end
    end
    queue_beat(OP_SAMPLE, row, col, ch, $urandom_range(255));
  endfunction

  function automatic void random_beat(int span);
    int pick, row, col, ch;
    pick = $urandom_range(99);
    if (pick < 55) begin
      row = ($urandom_range(9) == 0) ? $urandom_range(COORD_TOP) : $urandom_range(span);
      col = ($urandom_range(9) == 0) ? $urandom_range(COORD_TOP) : $urandom_range(span);
      ch  = ($urandom_range(19) == 0) ? CH_TOP : $urandom_range(NCH - 1);
      queue_sample(row, col, ch);
    end else if (pick < 90) begin
      row = $urandom_range(1) ? $urandom_range(MAX_H - 1) : $urandom_range(span);
      col = $urandom_range(1) ? $urandom_range(MAX_W - 1) : $urandom_range(span);
      queue_beat(OP_WRITE, row, col, $urandom_range(NCH - 1), $urandom_range(255));
    end else begin
      row = $urandom_range(COORD_TOP);
      col = $urandom_range(COORD_TOP);
      ch  = $urandom_range(CH_TOP);
      case ($urandom_range(2))
        0:       row = $urandom_range(COORD_TOP, MAX_H);
        1:       col = $urandom_range(COORD_TOP, MAX_W);
        default: ch = CH_TOP;
      endcase
      queue_beat(OP_WRITE, row, col, ch, $urandom_range(255));
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_MODE:   mode_r = data[0];
      REG_X_STEP: x_step_r = data[STEP_W-1:0];
      REG_Y_STEP: y_step_r = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic mode, logic [STEP_W-1:0] xs, logic [STEP_W-1:0] ys);
    logic [CFG_DAT_W-1:0] junk;
    junk = CFG_DAT_W'($urandom);
    write_reg(REG_MODE, {junk[CFG_DAT_W-1:1], mode});
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_STEP, ys);
    write_reg(REG_SPARE, CFG_DAT_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic drain();
    @(negedge clk);
    while (n_taken != n_queued || due_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(logic mode, logic [STEP_W-1:0] xs, logic [STEP_W-1:0] ys,
                           int span, int beats, bit pause);
    int stop;
    set_config(mode, xs, ys);
    stop = n_queued + beats / 2;
    while (n_queued < stop) random_beat(span);
    if (pause) drain();
    stop = n_queued + beats - beats / 2;
    while (n_queued < stop) random_beat(span);
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_count,
             due_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_chan.valid || in_fire) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_beat = beats_to_send.pop_front();
          in_chan.valid     <= 1'b1;
          in_chan.operation <= next_beat.op;
          in_chan.row       <= next_beat.row;
          in_chan.col       <= next_beat.col;
          in_chan.channel   <= next_beat.ch;
          in_chan.value     <= next_beat.value;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    in_fire <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      n_taken++;
      take_beat(in_chan.operation, in_chan.row, in_chan.col, in_chan.channel, in_chan.value);
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (due_pixels.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected beat, expected none, actual pixel %0d channel %0d",
                 $time, out_chan.pixel_value, out_chan.channel_out);
      end else begin
        due = due_pixels.pop_front();
        n_checked++;
        if (out_chan.pixel_value !== due.pixel) begin
          n_errors++;
          $display("%0t: pixel_value expected %0d actual %0d", $time, due.pixel,
                   out_chan.pixel_value);
        end
        if (out_chan.channel_out !== due.ch) begin
          n_errors++;
          $display("%0t: channel_out expected %0d actual %0d", $time, due.ch,
                   out_chan.channel_out);
        end
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = REG_MODE;
    cfg_wdata         = '0;
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_WRITE;
    in_chan.row       = '0;
    in_chan.col       = '0;
    in_chan.channel   = '0;
    in_chan.value     = '0;
    out_chan.ready    = 1'b0;
    in_fire           = 1'b0;
    mode_r            = MODE_BILINEAR;
    x_step_r          = STEP_ONE;
    y_step_r          = STEP_ONE;
    send_idle_pct     = 7;
    recv_idle_pct     = 81;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: unit steps, copies only
    queue_beat(OP_WRITE, 0, 0, 0, 0);
    queue_beat(OP_WRITE, 0, 0, 1, 255);
    queue_beat(OP_WRITE, 0, 0, 2, 8'hA5);
    queue_beat(OP_WRITE, MAX_H - 1, MAX_W - 1, 0, 255);
    queue_beat(OP_WRITE, MAX_H - 1, MAX_W - 1, 1, 0);
    queue_beat(OP_WRITE, MAX_H - 1, MAX_W - 1, 2, 8'h5A);
    // ignored writes
    queue_beat(OP_WRITE, MAX_H, 0, 0, 8'h11);
    queue_beat(OP_WRITE, 0, COORD_TOP, 1, 8'h22);
    queue_beat(OP_WRITE, COORD_TOP, COORD_TOP, 2, 255);
    queue_beat(OP_WRITE, 5, 5, CH_TOP, 8'h33);
    queue_sample(0, 0, 0);
    queue_sample(0, 0, 1);
    queue_sample(0, 0, 2);
    queue_sample(0, 0, CH_TOP);
    queue_sample(COORD_TOP, COORD_TOP, 0);
    queue_sample(COORD_TOP, COORD_TOP, 1);
    queue_sample(MAX_H - 1, MAX_W - 1, 2);
    drain();

    // fractional blends, one saturated at the far edge
    set_config(MODE_BILINEAR, 24'h008000, 24'h018000);
    queue_sample(1, 1, 0);
    queue_sample(3, 2, 1);
    queue_sample(COORD_TOP, 0, 2);
    queue_sample(7, MAX_W - 1, 0);
    drain();

    run_phase(MODE_NEAREST, STEP_W'($urandom_range(24'h02FFFF, 24'h000100)),
              STEP_W'($urandom_range(24'h02FFFF, 24'h000100)), 63, 280, 1'b0);
    run_phase(MODE_BILINEAR, 24'h000000, 24'hFFFFFF, 63, 280, 1'b1);

    send_idle_pct = 81;
    recv_idle_pct = 7;
    run_phase(MODE_BILINEAR, STEP_W'($urandom_range(24'h02FFFF, 24'h000100)),
              STEP_W'($urandom_range(24'h02FFFF, 24'h000100)), 63, 290, 1'b0);
    run_phase(MODE_NEAREST, 24'hFFFFFF, 24'h000000, 63, 280, 1'b0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(MODE_BILINEAR, 24'h00C000, 24'h00A000, 80, 280, 1'b0);
    run_phase(MODE_BILINEAR, STEP_W'($urandom), STEP_W'($urandom), 63, 280, 1'b0);

    $display("covered %0d beats (%0d writes, %0d samples), %0d results compared",
             n_taken, n_writes, n_samples, n_checked);
    $display("over %0d register settings in both modes, steps 0 to full scale, %0d errors",
             n_settings, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
